// ----- design/rfcts_pkg.sv -----
// ----------------------------------------------------------------------------
// rfcts_pkg: shared types and constants for the timestamp parser
// Parser phases, captured field bundle, calendar tables and scale factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfcts_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_LEAD       = 3'd0,
		PH_CORE       = 3'd1,
		PH_ZONE       = 3'd2,
		PH_FRAC_FIRST = 3'd3,
		PH_FRAC_MORE  = 3'd4,
		PH_OFFSET     = 3'd5,
		PH_TRAIL      = 3'd6
	} phase_t;

	localparam int POS_W = 5;
	localparam int MS_W  = 49;

	// positions in the fixed date-time text
	localparam logic [POS_W-1:0] POS_DATE_SEP1 = 5'd4;
	localparam logic [POS_W-1:0] POS_DATE_SEP2 = 5'd7;
	localparam logic [POS_W-1:0] POS_DT_SEP    = 5'd10;
	localparam logic [POS_W-1:0] POS_TIME_SEP1 = 5'd13;
	localparam logic [POS_W-1:0] POS_TIME_SEP2 = 5'd16;
	localparam logic [POS_W-1:0] POS_CORE_LAST = 5'd18;
	// positions in the zone offset text
	localparam logic [POS_W-1:0] POS_OFF_SEP   = 5'd2;
	localparam logic [POS_W-1:0] POS_OFF_LAST  = 5'd4;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T_UP  = 8'h54;
	localparam logic [7:0] CH_T_LO  = 8'h74;
	localparam logic [7:0] CH_Z_UP  = 8'h5A;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;

	// limits
	localparam logic [6:0] MAX_MONTH  = 7'd12;
	localparam logic [6:0] MAX_HOUR   = 7'd23;
	localparam logic [6:0] MAX_MINUTE = 7'd59;
	localparam logic [1:0] FRAC_KEEP  = 2'd3;

	// scale factors
	localparam logic [26:0] DAY_MS    = 27'd86400000;
	localparam logic [21:0] HOUR_MS   = 22'd3600000;
	localparam logic [15:0] MIN_MS    = 16'd60000;
	localparam logic [9:0]  SEC_MS    = 10'd1000;
	// x/25 == (x*RECIP25) >> RECIP_SH for x < 4096
	localparam logic [12:0] RECIP25   = 13'd5243;
	localparam int          RECIP_SH  = 17;
	localparam logic [8:0]  YEAR_BIAS = 9'd400;
	localparam logic [19:0] EPOCH_DAYS = 20'd865565;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [9:0]  frac;
		logic [1:0]  frac_digits;
		logic        off_neg;
		logic [6:0]  off_hour;
		logic [6:0]  off_minute;
	} acc_t;

	typedef struct packed {
		acc_t acc;
		logic err;
		logic trail;
	} fields_t;

	function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
		logic [10:0] t;
		t = 11'(a) * 11'd10 + 11'(d);
		return t[6:0];
	endfunction

	function automatic logic [13:0] acc_year(input logic [13:0] a, input logic [3:0] d);
		logic [17:0] t;
		t = 18'(a) * 18'd10 + 18'(d);
		return t[13:0];
	endfunction

	function automatic logic [9:0] acc_frac(input logic [9:0] a, input logic [3:0] d);
		logic [13:0] t;
		t = 14'(a) * 14'd10 + 14'(d);
		return t[9:0];
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			7'd2:                      r = leap ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// day of a March-based year on which month m starts
	function automatic logic [8:0] month_doy(input logic [6:0] m);
		logic [8:0] r;
		case (m)
			7'd3:    r = 9'd0;
			7'd4:    r = 9'd31;
			7'd5:    r = 9'd61;
			7'd6:    r = 9'd92;
			7'd7:    r = 9'd122;
			7'd8:    r = 9'd153;
			7'd9:    r = 9'd184;
			7'd10:   r = 9'd214;
			7'd11:   r = 9'd245;
			7'd12:   r = 9'd275;
			7'd1:    r = 9'd306;
			7'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/rfcts_parse.sv -----
// ----------------------------------------------------------------------------
// rfcts_parse: character-level timestamp parser
// Updates field accumulators one character per cycle while take is high; snapshots on last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfcts_parse #(
	parameter int MAX_CHARS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          character,
	input  logic                last,
	output logic                snap_valid,
	output rfcts_pkg::fields_t  snap
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

	logic [CNT_W-1:0]            cnt_q, cnt_n;
	rfcts_pkg::phase_t           phase_q, ph_n;
	logic [rfcts_pkg::POS_W-1:0] pos_q, pos_n, core_p;
	rfcts_pkg::acc_t             acc_q, acc_n;
	logic                        err_q, err_n;

	logic       is_dig, is_ws, do_core, do_zone, do_frac;
	logic [3:0] dig;

	assign dig    = 4'(character - rfcts_pkg::CH_ZERO);
	assign is_dig = character inside {[rfcts_pkg::CH_ZERO:rfcts_pkg::CH_NINE]};
	assign is_ws  = character inside {rfcts_pkg::CH_SPACE, rfcts_pkg::CH_TAB,
		rfcts_pkg::CH_CR, rfcts_pkg::CH_LF};
	assign core_p = (phase_q == rfcts_pkg::PH_LEAD) ? '0 : pos_q;

	assign do_core = (phase_q == rfcts_pkg::PH_LEAD && !is_ws) || phase_q == rfcts_pkg::PH_CORE;
	assign do_zone = (phase_q == rfcts_pkg::PH_ZONE && character != rfcts_pkg::CH_DOT)
		|| (phase_q == rfcts_pkg::PH_FRAC_MORE && !is_dig);
	assign do_frac = is_dig && (phase_q == rfcts_pkg::PH_FRAC_FIRST
		|| phase_q == rfcts_pkg::PH_FRAC_MORE);

	always_comb begin
		cnt_n = cnt_q;
		ph_n  = phase_q;
		pos_n = pos_q;
		acc_n = acc_q;
		err_n = err_q;
		if (!err_q) begin
			if (cnt_q >= CNT_MAX) begin
				err_n = 1'b1;
			end else begin
				cnt_n = cnt_q + 1'b1;
				case (phase_q)
					rfcts_pkg::PH_LEAD, rfcts_pkg::PH_CORE: begin
						// handled below
					end
					rfcts_pkg::PH_ZONE: begin
						if (character == rfcts_pkg::CH_DOT) ph_n = rfcts_pkg::PH_FRAC_FIRST;
					end
					rfcts_pkg::PH_FRAC_FIRST: begin
						if (is_dig) ph_n = rfcts_pkg::PH_FRAC_MORE;
						else err_n = 1'b1;
					end
					rfcts_pkg::PH_FRAC_MORE: begin
						// digits and zone handled below
					end
					rfcts_pkg::PH_OFFSET: begin
						if (pos_q == rfcts_pkg::POS_OFF_SEP) begin
							if (character != rfcts_pkg::CH_COLON) err_n = 1'b1;
						end else if (!is_dig) begin
							err_n = 1'b1;
						end else if (pos_q < rfcts_pkg::POS_OFF_SEP) begin
							acc_n.off_hour = rfcts_pkg::acc2(acc_q.off_hour, dig);
						end else begin
							acc_n.off_minute = rfcts_pkg::acc2(acc_q.off_minute, dig);
						end
						if (pos_q >= rfcts_pkg::POS_OFF_LAST) ph_n = rfcts_pkg::PH_TRAIL;
						else pos_n = pos_q + 1'b1;
					end
					rfcts_pkg::PH_TRAIL: begin
						if (!is_ws) err_n = 1'b1;
					end
					default: err_n = 1'b1;
				endcase

				if (do_core) begin
					case (core_p)
						rfcts_pkg::POS_DATE_SEP1, rfcts_pkg::POS_DATE_SEP2: begin
							if (character != rfcts_pkg::CH_DASH) err_n = 1'b1;
						end
						rfcts_pkg::POS_DT_SEP: begin
							if (character != rfcts_pkg::CH_T_UP && character != rfcts_pkg::CH_T_LO)
								err_n = 1'b1;
						end
						rfcts_pkg::POS_TIME_SEP1, rfcts_pkg::POS_TIME_SEP2: begin
							if (character != rfcts_pkg::CH_COLON) err_n = 1'b1;
						end
						default: begin
							if (!is_dig) err_n = 1'b1;
							else if (core_p < rfcts_pkg::POS_DATE_SEP1)
								acc_n.year = rfcts_pkg::acc_year(acc_q.year, dig);
							else if (core_p < rfcts_pkg::POS_DATE_SEP2)
								acc_n.month = rfcts_pkg::acc2(acc_q.month, dig);
							else if (core_p < rfcts_pkg::POS_DT_SEP)
								acc_n.day = rfcts_pkg::acc2(acc_q.day, dig);
							else if (core_p < rfcts_pkg::POS_TIME_SEP1)
								acc_n.hour = rfcts_pkg::acc2(acc_q.hour, dig);
							else if (core_p < rfcts_pkg::POS_TIME_SEP2)
								acc_n.minute = rfcts_pkg::acc2(acc_q.minute, dig);
							else
								acc_n.second = rfcts_pkg::acc2(acc_q.second, dig);
						end
					endcase
					if (core_p >= rfcts_pkg::POS_CORE_LAST) begin
						ph_n = rfcts_pkg::PH_ZONE;
					end else begin
						ph_n  = rfcts_pkg::PH_CORE;
						pos_n = core_p + 1'b1;
					end
				end

				// fraction: only the first three digits count
				if (do_frac && acc_q.frac_digits < rfcts_pkg::FRAC_KEEP) begin
					acc_n.frac        = rfcts_pkg::acc_frac(acc_q.frac, dig);
					acc_n.frac_digits = acc_q.frac_digits + 1'b1;
				end

				if (do_zone) begin
					if (character == rfcts_pkg::CH_Z_UP || character == rfcts_pkg::CH_Z_LO) begin
						ph_n = rfcts_pkg::PH_TRAIL;
					end else if (character == rfcts_pkg::CH_PLUS
						|| character == rfcts_pkg::CH_DASH) begin
						acc_n.off_neg = (character == rfcts_pkg::CH_DASH);
						pos_n         = '0;
						ph_n          = rfcts_pkg::PH_OFFSET;
					end else begin
						err_n = 1'b1;
					end
				end
			end
		end
	end

	assign snap_valid  = take && last;
	assign snap.acc    = acc_n;
	assign snap.err    = err_n;
	assign snap.trail  = (ph_n == rfcts_pkg::PH_TRAIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= rfcts_pkg::PH_LEAD;
			pos_q   <= '0;
			acc_q   <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				cnt_q   <= '0;
				phase_q <= rfcts_pkg::PH_LEAD;
				pos_q   <= '0;
				acc_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				cnt_q   <= cnt_n;
				phase_q <= ph_n;
				pos_q   <= pos_n;
				acc_q   <= acc_n;
				err_q   <= err_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> phase_q == rfcts_pkg::PH_LEAD && cnt_q == '0 && !err_q)
		else $error("parser not back at start after last character");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("character count beyond limit");
`endif

endmodule

// ----- design/rfcts_conv.sv -----
// ----------------------------------------------------------------------------
// rfcts_conv: calendar check and Unix millisecond conversion pipeline
// Three stages plus output register, each stage holds while downstream stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfcts_conv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       snap_valid,
	input  rfcts_pkg::fields_t         snap,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_ok,
	output logic [rfcts_pkg::MS_W-1:0] out_ms
);

	// stage 1: captured fields
	logic               v_s1;
	rfcts_pkg::fields_t f_s1;

	// stage 2: reciprocal products and time-of-day parts
	logic        v_s2, ok_s2, off_neg_s2;
	logic [13:0] ys_s2, year_s2;
	logic [6:0]  month_s2, day_s2;
	logic [7:0]  c100_s2, y100_s2;
	logic [5:0]  c400_s2;
	logic [28:0] hour_ms_s2;
	logic [22:0] min_ms_s2;
	logic [16:0] sec_ms_s2;
	logic [9:0]  frac_s2;
	logic [12:0] off_min_s2;

	// stage 3: day number and time of day
	logic               v_s3, ok_s3;
	logic signed [23:0] days_s3;
	logic signed [29:0] tod_s3;

	// output register
	logic                       res_valid_q, res_ok_q;
	logic [rfcts_pkg::MS_W-1:0] res_ms_q;

	logic rdy_o, rdy3, rdy2, rdy1;
	assign rdy_o    = !res_valid_q || out_ready;
	assign rdy3     = !v_s3 || rdy_o;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// ---- stage 1 -> 2 ----
	logic [14:0] ys_w;
	logic [13:0] ys;
	logic [24:0] p100, py;
	logic [22:0] p400;
	logic        ok_a;
	logic [9:0]  frac_sc;

	assign ys_w = 15'(f_s1.acc.year) + 15'(rfcts_pkg::YEAR_BIAS)
		- 15'(f_s1.acc.month <= 7'd2);
	assign ys   = ys_w[13:0];
	assign p100 = 25'(ys[13:2]) * 25'(rfcts_pkg::RECIP25);
	assign p400 = 23'(ys[13:4]) * 23'(rfcts_pkg::RECIP25);
	assign py   = 25'(f_s1.acc.year[13:2]) * 25'(rfcts_pkg::RECIP25);

	assign ok_a = !f_s1.err && f_s1.trail
		&& f_s1.acc.month >= 7'd1 && f_s1.acc.month <= rfcts_pkg::MAX_MONTH
		&& f_s1.acc.day >= 7'd1
		&& f_s1.acc.hour <= rfcts_pkg::MAX_HOUR
		&& f_s1.acc.minute <= rfcts_pkg::MAX_MINUTE
		&& f_s1.acc.second <= rfcts_pkg::MAX_MINUTE
		&& f_s1.acc.off_hour <= rfcts_pkg::MAX_HOUR
		&& f_s1.acc.off_minute <= rfcts_pkg::MAX_MINUTE;

	// pad short fractions to milliseconds
	always_comb begin
		case (f_s1.acc.frac_digits)
			2'd1:    frac_sc = 10'(14'(f_s1.acc.frac) * 14'd100);
			2'd2:    frac_sc = 10'(14'(f_s1.acc.frac) * 14'd10);
			2'd3:    frac_sc = f_s1.acc.frac;
			default: frac_sc = '0;
		endcase
	end

	// ---- stage 2 -> 3 ----
	logic               leap;
	logic [4:0]         mdays;
	logic [23:0]        days_u;
	logic [28:0]        off_ms;
	logic [29:0]        tod_pos;

	assign leap  = (year_s2[1:0] == 2'b00)
		&& (year_s2 != 14'(y100_s2) * 14'd100 || y100_s2[1:0] == 2'b00);
	assign mdays = rfcts_pkg::month_len(month_s2, leap);

	// days since epoch over a 400-year-shifted year, era terms folded in
	assign days_u = 24'(ys_s2) * 24'd365 + 24'(ys_s2[13:2]) - 24'(c100_s2) + 24'(c400_s2)
		+ 24'(rfcts_pkg::month_doy(month_s2)) + 24'(day_s2) - 24'd1
		- 24'(rfcts_pkg::EPOCH_DAYS);

	assign off_ms  = 29'(off_min_s2) * 29'(rfcts_pkg::MIN_MS);
	assign tod_pos = 30'(hour_ms_s2) + 30'(min_ms_s2) + 30'(sec_ms_s2) + 30'(frac_s2);

	// ---- stage 3 -> out ----
	logic signed [50:0]         prod;
	logic [rfcts_pkg::MS_W-1:0] ms;

	assign prod = days_s3 * $signed({1'b0, rfcts_pkg::DAY_MS});
	assign ms   = prod[rfcts_pkg::MS_W-1:0]
		+ {{(rfcts_pkg::MS_W-30){tod_s3[29]}}, tod_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy1)  v_s1        <= snap_valid;
			if (rdy2)  v_s2        <= v_s1;
			if (rdy3)  v_s3        <= v_s2;
			if (rdy_o) res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && snap_valid) f_s1 <= snap;
		if (rdy2 && v_s1) begin
			ys_s2      <= ys;
			year_s2    <= f_s1.acc.year;
			month_s2   <= f_s1.acc.month;
			day_s2     <= f_s1.acc.day;
			c100_s2    <= p100[24:rfcts_pkg::RECIP_SH];
			c400_s2    <= p400[22:rfcts_pkg::RECIP_SH];
			y100_s2    <= py[24:rfcts_pkg::RECIP_SH];
			ok_s2      <= ok_a;
			hour_ms_s2 <= 29'(f_s1.acc.hour) * 29'(rfcts_pkg::HOUR_MS);
			min_ms_s2  <= 23'(f_s1.acc.minute) * 23'(rfcts_pkg::MIN_MS);
			sec_ms_s2  <= 17'(f_s1.acc.second) * 17'(rfcts_pkg::SEC_MS);
			frac_s2    <= frac_sc;
			off_neg_s2 <= f_s1.acc.off_neg;
			off_min_s2 <= 13'(f_s1.acc.off_hour) * 13'd60 + 13'(f_s1.acc.off_minute);
		end
		if (rdy3 && v_s2) begin
			ok_s3   <= ok_s2 && (day_s2 <= 7'(mdays));
			days_s3 <= $signed(days_u);
			tod_s3  <= off_neg_s2 ? $signed(tod_pos + 30'(off_ms))
				: $signed(tod_pos - 30'(off_ms));
		end
		if (rdy_o && v_s3) begin
			res_ok_q <= ok_s3;
			res_ms_q <= ok_s3 ? ms : '0;
		end
	end

	assign out_valid = res_valid_q;
	assign out_ok    = res_ok_q;
	assign out_ms    = res_ms_q;

`ifndef NO_ASSERTIONS
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && res_valid_q)
		else $error("input stalled while pipeline has a free slot");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ok_q |-> res_ms_q == '0)
		else $error("invalid result carries nonzero time");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && in_ready |=> v_s1)
		else $error("snapshot lost at stage 1");
`endif

endmodule

// ----- design/rfc3339_timestamp_to_unix_ms_top.sv -----
// ----------------------------------------------------------------------------
// rfc3339_timestamp_to_unix_ms_top: RFC 3339 text to Unix milliseconds
// Result path: tlast fields pass stage 1, 2, 3, then the output register.
// Throughput: one character per cycle while tready is high, back to back, across timestamp ends.
// Rate is set by the per-character parser state update.
// Reset: arst_n clears parser state and all stage valid flags at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfc3339_timestamp_to_unix_ms_top #(
	parameter int MAX_CHARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// character stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	input  logic        s_axis_tlast,   // last character of the timestamp
	// result stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [48:0] unix_ms (two's complement), [55:49] zero
	output logic        m_axis_tuser    // [0] valid_res
);

	// A character transaction goes straight into the parser state; a tlast
	// transaction also snapshots the updated fields into the conversion
	// pipeline, and the parser restarts for the next timestamp.
	logic                       take;
	logic                       snap_valid;
	rfcts_pkg::fields_t         snap;
	logic                       ok;
	logic [rfcts_pkg::MS_W-1:0] ms;

	assign take = s_axis_tvalid && s_axis_tready;

	rfcts_parse #(
		.MAX_CHARS (MAX_CHARS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.character  (s_axis_tdata),
		.last       (s_axis_tlast),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	// Conversion: stage 1 holds the fields, stage 2 the divide-by-25
	// products and scaled time parts, stage 3 the day number and time of
	// day, then the output register with days * 86400000 added in.
	// tready drops only when every stage is full and the output is stalled.
	rfcts_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_ok     (ok),
		.out_ms     (ms)
	);

	assign m_axis_tdata = {{(56 - rfcts_pkg::MS_W){1'b0}}, ms};
	assign m_axis_tuser = ok;

endmodule
